### hw/rtl/vrts_pkg.sv
// Package for the oscillator tuning sequencer: command and step types,
// register addresses, per-band constant tables and the reciprocal constant.
// No dependencies; every other file of the block but vrts_if uses it.
package vrts_pkg;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_SET   = 2'd1,
        OP_CLR   = 2'd2
    } t_op;

    typedef enum logic [3:0] {
        ST_FREEZE    = 4'd0,
        ST_HS_N1     = 4'd1,
        ST_N1_RF     = 4'd2,
        ST_CTR_B3    = 4'd3,
        ST_CTR_B2    = 4'd4,
        ST_CTR_B1    = 4'd5,
        ST_CTR_B0    = 4'd6,
        ST_UNFREEZE  = 4'd7,
        ST_NEWFREQ   = 4'd8,
        ST_MEM_HOLD  = 4'd9,
        ST_RF_B3     = 4'd10,
        ST_RF_B2     = 4'd11,
        ST_RF_B1     = 4'd12,
        ST_RF_B0     = 4'd13,
        ST_MEM_FREE  = 4'd14
    } t_step;

    typedef struct packed {
        logic [3:0]  band;
        logic        chg;
        logic [31:0] rf;
    } t_job;

    typedef struct packed {
        t_op        op;
        logic [7:0] addr;
        logic [7:0] data;
        logic       last;
    } t_cmd;

    localparam logic [3:0]  TABLE_BANDS    = 4'd11;
    localparam logic [3:0]  NO_BAND        = 4'd15;

    localparam logic [7:0]  ADDR_HS_N1     = 8'd13;
    localparam logic [7:0]  ADDR_N1_RF     = 8'd14;
    localparam logic [7:0]  ADDR_RF_B3     = 8'd15;
    localparam logic [7:0]  ADDR_RF_B2     = 8'd16;
    localparam logic [7:0]  ADDR_RF_B1     = 8'd17;
    localparam logic [7:0]  ADDR_RF_B0     = 8'd18;
    localparam logic [7:0]  ADDR_FREQ_CTRL = 8'd135;
    localparam logic [7:0]  ADDR_FREEZE    = 8'd137;

    localparam logic [7:0]  FREEZE_DCO     = 8'h10;
    localparam logic [7:0]  CTRL_NEWFREQ   = 8'h40;
    localparam logic [7:0]  CTRL_FREEZE_M  = 8'h20;
    localparam logic [7:0]  CTRL_NONE      = 8'h00;

    // ceil(2^36 / 1000); exact floor division for any 26-bit dividend.
    localparam logic [26:0] RECIP_1K       = 27'd68719477;
    localparam int          RECIP_1K_SHIFT = 36;

    function automatic logic [31:0] center_rfreq(input logic [3:0] b);
        logic [31:0] v;
        case (b)
            4'd0:    v = 32'hD95B8650;
            4'd1:    v = 32'hEC0189AD;
            4'd2:    v = 32'hCD16C87C;
            4'd3:    v = 32'hE89426CF;
            4'd4:    v = 32'h0E006F4A;
            4'd5:    v = 32'hB66E36BC;
            4'd6:    v = 32'hB51E74B5;
            4'd7:    v = 32'hD13481BB;
            4'd8:    v = 32'hEA3AB75E;
            4'd9:    v = 32'hEE11348D;
            4'd10:   v = 32'hF29A73A4;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] hs_div_byte(input logic [3:0] b);
        logic [7:0] v;
        case (b)
            4'd2, 4'd3, 4'd4: v = 8'hE1;
            4'd5:             v = 8'h61;
            default:          v = 8'hA1;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] n1_byte(input logic [3:0] b);
        logic [7:0] v;
        case (b)
            4'd0, 4'd1, 4'd5: v = 8'hC2;
            4'd4:             v = 8'h43;
            default:          v = 8'h42;
        endcase
        return v;
    endfunction

    function automatic logic [24:0] center_hz(input logic [3:0] b);
        logic [24:0] v;
        case (b)
            4'd0:    v = 25'd1900000;
            4'd1:    v = 25'd3750000;
            4'd2:    v = 25'd7150000;
            4'd3:    v = 25'd10125000;
            4'd4:    v = 25'd14175000;
            4'd5:    v = 25'd18118000;
            4'd6:    v = 25'd21225000;
            4'd7:    v = 25'd24940000;
            4'd8:    v = 25'd28250000;
            4'd9:    v = 25'd28757640;
            4'd10:   v = 25'd29357640;
            default: v = 25'd0;
        endcase
        return v;
    endfunction

    function automatic logic [17:0] step_1k(input logic [3:0] b);
        logic [17:0] v;
        case (b)
            4'd0:                   v = 18'h2949B;
            4'd1, 4'd2, 4'd3, 4'd4: v = 18'h25D8E;
            4'd5:                   v = 18'h201CE;
            default:                v = 18'h1EF74;
        endcase
        return v;
    endfunction

    function automatic logic [15:0] step_100(input logic [3:0] b);
        logic [15:0] v;
        case (b)
            4'd0:                   v = 16'h420F;
            4'd1, 4'd2, 4'd3, 4'd4: v = 16'h3C8E;
            4'd5:                   v = 16'h3361;
            default:                v = 16'h318B;
        endcase
        return v;
    endfunction

    function automatic logic [10:0] step_10(input logic [3:0] b);
        logic [10:0] v;
        case (b)
            4'd0:                   v = 11'h69B;
            4'd1, 4'd2, 4'd3, 4'd4: v = 11'h60E;
            4'd5:                   v = 11'h523;
            default:                v = 11'h4F4;
        endcase
        return v;
    endfunction

    function automatic logic [8:0] cal_hz(input logic [3:0] b);
        logic [8:0] v;
        case (b)
            4'd0:    v = 9'd120;
            4'd2:    v = 9'd269;
            4'd3:    v = 9'd260;
            4'd4:    v = 9'd240;
            4'd5:    v = 9'd279;
            default: v = 9'd150;
        endcase
        return v;
    endfunction

endpackage

### hw/rtl/vrts_if.sv
// Channel interfaces of the tuning sequencer: tuning requests in and
// oscillator register commands out, each with valid/ready handshake.
// No dependencies.
interface vrts_req_if;
    logic        valid;
    logic        ready;
    logic [24:0] freq_hz;
    logic [3:0]  band;

    modport source(output valid, output freq_hz, output band, input ready);
    modport sink(input valid, input freq_hz, input band, output ready);
endinterface

interface vrts_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic [7:0] reg_addr;
    logic [7:0] reg_data;
    logic       last;

    modport source(output valid, output op, output reg_addr, output reg_data, output last,
                   input ready);
    modport sink(input valid, input op, input reg_addr, input reg_data, input last,
                 output ready);
endinterface

### hw/rtl/vrts_front.sv
// Front end: accepts tuning requests, tracks the loaded band and computes
// the new RFREQ word in a seven-stage pipeline. Uses vrts_pkg, vrts_if.
module vrts_front #(
    parameter int NUM_BANDS = 11
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    vrts_req_if.sink          i_req,
    output logic              o_job_valid,
    input  logic              i_job_ready,
    output vrts_pkg::t_job    o_job
);

    logic        en;
    logic        accept;
    logic        band_ok;
    logic [25:0] cal;
    logic [25:0] ctr;
    logic [52:0] prod;
    logic [25:0] rem_full;
    logic [15:0] m41;
    logic [17:0] m205;
    logic [6:0]  te_full;
    logic [31:0] delta;

    logic [3:0]  r_active_band;
    logic [6:0]  r_v;
    logic [3:0]  r_band [7];
    logic        r_chg  [7];
    logic        r_neg  [7];

    logic [25:0] r_s0_off;
    logic [25:0] r_s1_off;
    logic [15:0] r_s1_th;
    logic [15:0] r_s2_th;
    logic [9:0]  r_s2_rem;
    logic [15:0] r_s3_th;
    logic [3:0]  r_s3_hu;
    logic [6:0]  r_s3_t10;
    logic [3:0]  r_s4_te;
    logic [31:0] r_s4_p1;
    logic [31:0] r_s4_p2;
    logic [31:0] r_s5_p3;
    logic [31:0] r_s5_s12;
    logic [31:0] r_s6_rf;

    assign en          = !r_v[6] || i_job_ready;
    assign i_req.ready = en;
    assign accept      = i_req.valid && i_req.ready;
    assign band_ok     = ({1'b0, i_req.band} < 5'(NUM_BANDS))
                         && (i_req.band < vrts_pkg::TABLE_BANDS);

    assign cal      = {1'b0, i_req.freq_hz} + 26'(vrts_pkg::cal_hz(i_req.band));
    assign ctr      = 26'(vrts_pkg::center_hz(i_req.band));
    assign prod     = 53'(r_s0_off) * 53'(vrts_pkg::RECIP_1K);
    assign rem_full = r_s1_off - 26'(r_s1_th) * 26'd1000;
    assign m41      = 16'(r_s2_rem) * 16'd41;
    assign m205     = 18'(r_s2_rem) * 18'd205;
    assign te_full  = r_s3_t10 - 7'(r_s3_hu) * 7'd10;
    assign delta    = r_s5_s12 + r_s5_p3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_band <= vrts_pkg::NO_BAND;
            r_v           <= '0;
        end else begin
            if (accept && band_ok) begin
                r_active_band <= i_req.band;
            end
            if (en) begin
                r_v <= {r_v[5:0], accept && band_ok};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_band[0] <= i_req.band;
            r_chg[0]  <= i_req.band != r_active_band;
            r_neg[0]  <= cal < ctr;
            r_s0_off  <= (cal < ctr) ? (ctr - cal) : (cal - ctr);
            for (int i = 1; i < 7; i++) begin
                r_band[i] <= r_band[i-1];
                r_chg[i]  <= r_chg[i-1];
                r_neg[i]  <= r_neg[i-1];
            end
            r_s1_off <= r_s0_off;
            r_s1_th  <= prod[vrts_pkg::RECIP_1K_SHIFT +: 16];
            r_s2_th  <= r_s1_th;
            r_s2_rem <= rem_full[9:0];
            r_s3_th  <= r_s2_th;
            r_s3_hu  <= m41[15:12];
            r_s3_t10 <= m205[17:11];
            r_s4_te  <= te_full[3:0];
            r_s4_p1  <= 32'(r_s3_th) * 32'(vrts_pkg::step_1k(r_band[3]));
            r_s4_p2  <= 32'(r_s3_hu) * 32'(vrts_pkg::step_100(r_band[3]));
            r_s5_p3  <= 32'(r_s4_te) * 32'(vrts_pkg::step_10(r_band[4]));
            r_s5_s12 <= r_s4_p1 + r_s4_p2;
            r_s6_rf  <= r_neg[5] ? (vrts_pkg::center_rfreq(r_band[5]) - delta)
                                 : (vrts_pkg::center_rfreq(r_band[5]) + delta);
        end
    end

    assign o_job_valid = r_v[6];
    assign o_job.band  = r_band[6];
    assign o_job.chg   = r_chg[6];
    assign o_job.rf    = r_s6_rf;

    a_drop_keeps_band: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !band_ok) |=> $stable(r_active_band))
        else $error("Ignored request changed the loaded band.");

    a_digits_decimal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_v[3] || r_s3_hu <= 4'd9) && (!r_v[4] || r_s4_te <= 4'd9))
        else $error("Hundreds or tens digit out of decimal range.");

endmodule

### hw/rtl/vrts_queue.sv
// Two-entry job queue between the front end and the command sequencer.
// Uses vrts_pkg for the job type.
module vrts_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push_valid,
    output logic              o_push_ready,
    input  vrts_pkg::t_job    i_push_job,
    output logic              o_pop_valid,
    input  logic              i_pop_ready,
    output vrts_pkg::t_job    o_pop_job
);

    vrts_pkg::t_job r_mem [2];
    logic           r_wr;
    logic           r_rd;
    logic [1:0]     r_count;
    logic           push;
    logic           pop;

    assign o_push_ready = r_count != 2'd2;
    assign o_pop_valid  = r_count != 2'd0;
    assign o_pop_job    = r_mem[r_rd];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (push) begin
                r_wr <= !r_wr;
            end
            if (pop) begin
                r_rd <= !r_rd;
            end
            r_count <= r_count + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_push_job;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != 2'd3) && ((r_wr == r_rd) == (r_count != 2'd1)))
        else $error("Queue pointers and fill count disagree.");

endmodule

### hw/rtl/vrts_back.sv
// Command sequencer: walks the band-change and retune command sequence for
// the job at the head of the queue into a registered output. Uses vrts_pkg.
module vrts_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_job_valid,
    output logic              o_job_ready,
    input  vrts_pkg::t_job    i_job,
    vrts_cmd_if.source        o_cmd
);

    vrts_pkg::t_step r_step;
    vrts_pkg::t_step n_step;
    vrts_pkg::t_step cur_step;
    logic            r_started;
    logic            n_started;
    vrts_pkg::t_cmd  r_out;
    vrts_pkg::t_cmd  cmd;
    logic            r_out_v;
    logic            load;
    logic [31:0]     ctr_rf;

    assign load     = i_job_valid && (!r_out_v || o_cmd.ready);
    assign ctr_rf   = vrts_pkg::center_rfreq(i_job.band);
    assign cur_step = r_started ? r_step
                    : (i_job.chg ? vrts_pkg::ST_FREEZE : vrts_pkg::ST_MEM_HOLD);

    always_comb begin
        cmd         = '{op: vrts_pkg::OP_WRITE, addr: vrts_pkg::ADDR_FREQ_CTRL,
                        data: vrts_pkg::CTRL_NONE, last: 1'b0};
        n_step      = r_step;
        n_started   = r_started;
        o_job_ready = 1'b0;
        unique case (cur_step)
            vrts_pkg::ST_FREEZE: begin
                cmd.op   = vrts_pkg::OP_SET;
                cmd.addr = vrts_pkg::ADDR_FREEZE;
                cmd.data = vrts_pkg::FREEZE_DCO;
            end
            vrts_pkg::ST_HS_N1: begin
                cmd.addr = vrts_pkg::ADDR_HS_N1;
                cmd.data = vrts_pkg::hs_div_byte(i_job.band);
            end
            vrts_pkg::ST_N1_RF: begin
                cmd.addr = vrts_pkg::ADDR_N1_RF;
                cmd.data = vrts_pkg::n1_byte(i_job.band);
            end
            vrts_pkg::ST_CTR_B3: begin
                cmd.addr = vrts_pkg::ADDR_RF_B3;
                cmd.data = ctr_rf[31:24];
            end
            vrts_pkg::ST_CTR_B2: begin
                cmd.addr = vrts_pkg::ADDR_RF_B2;
                cmd.data = ctr_rf[23:16];
            end
            vrts_pkg::ST_CTR_B1: begin
                cmd.addr = vrts_pkg::ADDR_RF_B1;
                cmd.data = ctr_rf[15:8];
            end
            vrts_pkg::ST_CTR_B0: begin
                cmd.addr = vrts_pkg::ADDR_RF_B0;
                cmd.data = ctr_rf[7:0];
            end
            vrts_pkg::ST_UNFREEZE: begin
                cmd.op   = vrts_pkg::OP_CLR;
                cmd.addr = vrts_pkg::ADDR_FREEZE;
                cmd.data = vrts_pkg::FREEZE_DCO;
            end
            vrts_pkg::ST_NEWFREQ: begin
                cmd.data = vrts_pkg::CTRL_NEWFREQ;
            end
            vrts_pkg::ST_MEM_HOLD: begin
                cmd.data = vrts_pkg::CTRL_FREEZE_M;
            end
            vrts_pkg::ST_RF_B3: begin
                cmd.addr = vrts_pkg::ADDR_RF_B3;
                cmd.data = i_job.rf[31:24];
            end
            vrts_pkg::ST_RF_B2: begin
                cmd.addr = vrts_pkg::ADDR_RF_B2;
                cmd.data = i_job.rf[23:16];
            end
            vrts_pkg::ST_RF_B1: begin
                cmd.addr = vrts_pkg::ADDR_RF_B1;
                cmd.data = i_job.rf[15:8];
            end
            vrts_pkg::ST_RF_B0: begin
                cmd.addr = vrts_pkg::ADDR_RF_B0;
                cmd.data = i_job.rf[7:0];
            end
            vrts_pkg::ST_MEM_FREE: begin
                cmd.last = 1'b1;
            end
            default: begin
                cmd.last = 1'b1;
            end
        endcase
        if (load) begin
            if (cmd.last) begin
                n_started   = 1'b0;
                n_step      = vrts_pkg::ST_FREEZE;
                o_job_ready = 1'b1;
            end else begin
                n_started = 1'b1;
                n_step    = vrts_pkg::t_step'(cur_step + 4'd1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step    <= vrts_pkg::ST_FREEZE;
            r_started <= 1'b0;
            r_out_v   <= 1'b0;
        end else begin
            r_step    <= n_step;
            r_started <= n_started;
            if (load) begin
                r_out_v <= 1'b1;
            end else if (o_cmd.ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= cmd;
        end
    end

    assign o_cmd.valid    = r_out_v;
    assign o_cmd.op       = r_out.op;
    assign o_cmd.reg_addr = r_out.addr;
    assign o_cmd.reg_data = r_out.data;
    assign o_cmd.last     = r_out.last;

    a_job_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_started |-> i_job_valid)
        else $error("Job left the queue in the middle of its sequence.");

    a_last_is_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && r_out.last) |->
            (r_out.addr == vrts_pkg::ADDR_FREQ_CTRL && r_out.data == vrts_pkg::CTRL_NONE))
        else $error("Final command of a request is not the control release.");

endmodule

### hw/rtl/vfo_rfreq_tuning_sequencer.sv
// Oscillator tuning sequencer, top level. Uses vrts_pkg, vrts_if,
// vrts_front, vrts_queue and vrts_back.
//
// A request (frequency in hertz, band) is accepted in any cycle the front
// pipeline can move, one per cycle, and passes through the front pipeline
// registers to the command queue. Requests with a band above ten, or at or
// beyond NUM_BANDS, produce no commands. The sequencer then issues one
// register command per cycle while the consumer takes them: six commands for
// a retune within the loaded band, fifteen when the band changes, the last
// one flagged. The sequencer sets the sustained request rate; a two-entry
// queue lets new requests be taken while commands still go out.
module vfo_rfreq_tuning_sequencer #(
    parameter int NUM_BANDS = 11
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    vrts_req_if.sink    i_req,
    vrts_cmd_if.source  o_cmd
);

    logic           fq_valid;
    logic           fq_ready;
    vrts_pkg::t_job fq_job;
    logic           qb_valid;
    logic           qb_ready;
    vrts_pkg::t_job qb_job;

    vrts_front #(
        .NUM_BANDS (NUM_BANDS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_job_valid (fq_valid),
        .i_job_ready (fq_ready),
        .o_job       (fq_job)
    );

    vrts_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (fq_valid),
        .o_push_ready (fq_ready),
        .i_push_job   (fq_job),
        .o_pop_valid  (qb_valid),
        .i_pop_ready  (qb_ready),
        .o_pop_job    (qb_job)
    );

    vrts_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (qb_valid),
        .o_job_ready (qb_ready),
        .i_job       (qb_job),
        .o_cmd       (o_cmd)
    );

endmodule

### sim/vfo_rfreq_tuning_sequencer_tb.sv
`timescale 1ns / 100ps
// Testbench for vfo_rfreq_tuning_sequencer: a directed table of tuning requests,
// then random ones, each command checked in order against a local band-table model.
// Uses vrts_pkg, the channel interfaces in vrts_if.sv and the block's top level.
module vfo_rfreq_tuning_sequencer_tb;
    import vrts_pkg::*;

    localparam int NUM_BANDS = 11;
    localparam int N_RANDOM  = 135;

    localparam logic [31:0] CTR_RFREQ [0:10] = '{
        32'hD95B8650, 32'hEC0189AD, 32'hCD16C87C, 32'hE89426CF, 32'h0E006F4A,
        32'hB66E36BC, 32'hB51E74B5, 32'hD13481BB, 32'hEA3AB75E, 32'hEE11348D,
        32'hF29A73A4};
    localparam logic [7:0] HS_BYTE [0:10] = '{
        8'hA1, 8'hA1, 8'hE1, 8'hE1, 8'hE1, 8'h61, 8'hA1, 8'hA1, 8'hA1, 8'hA1, 8'hA1};
    localparam logic [7:0] N1_BYTE [0:10] = '{
        8'hC2, 8'hC2, 8'h42, 8'h42, 8'h43, 8'hC2, 8'h42, 8'h42, 8'h42, 8'h42, 8'h42};
    localparam logic [31:0] CTR_HZ [0:10] = '{
        32'd1900000, 32'd3750000, 32'd7150000, 32'd10125000, 32'd14175000,
        32'd18118000, 32'd21225000, 32'd24940000, 32'd28250000, 32'd28757640,
        32'd29357640};
    localparam logic [31:0] STEP_1K [0:10] = '{
        32'h2949B, 32'h25D8E, 32'h25D8E, 32'h25D8E, 32'h25D8E, 32'h201CE,
        32'h1EF74, 32'h1EF74, 32'h1EF74, 32'h1EF74, 32'h1EF74};
    localparam logic [31:0] STEP_100 [0:10] = '{
        32'h420F, 32'h3C8E, 32'h3C8E, 32'h3C8E, 32'h3C8E, 32'h3361,
        32'h318B, 32'h318B, 32'h318B, 32'h318B, 32'h318B};
    localparam logic [31:0] STEP_10 [0:10] = '{
        32'h69B, 32'h60E, 32'h60E, 32'h60E, 32'h60E, 32'h523,
        32'h4F4, 32'h4F4, 32'h4F4, 32'h4F4, 32'h4F4};
    localparam logic [31:0] CAL_HZ [0:10] = '{
        32'd120, 32'd150, 32'd269, 32'd260, 32'd240, 32'd279,
        32'd150, 32'd150, 32'd150, 32'd150, 32'd150};

    localparam int SRC_IDLE [0:3] = '{0, 76, 0, 20};
    localparam int SNK_STALL [0:3] = '{0, 0, 76, 20};

    typedef struct packed {
        logic [24:0] freq;
        logic [3:0]  band;
        logic        pinned;
        logic [31:0] rf;
    } t_row;

    // Pinned rows carry the expected RFREQ, given directly instead of computed by the model.
    localparam t_row DIRECTED [0:24] = '{
        {25'd1899880,     4'd0,  1'b1, 32'hD95B8650},
        {25'd1899880,     4'd0,  1'b1, 32'hD95B8650},
        {25'd1899889,     4'd0,  1'b1, 32'hD95B8650},
        {25'd1899871,     4'd0,  1'b1, 32'hD95B8650},
        {25'd1899890,     4'd0,  1'b1, 32'hD95B8CEB},
        {25'd1898880,     4'd0,  1'b1, 32'hD958F1B5},
        {25'd0,           4'd0,  1'b0, 32'h0},
        {25'h1FFFFFF,     4'd0,  1'b0, 32'h0},
        {25'd1899880,     4'd11, 1'b0, 32'h0},
        {25'h1FFFFFF,     4'd15, 1'b0, 32'h0},
        {25'd1899880,     4'd0,  1'b1, 32'hD95B8650},
        {25'd14174760,    4'd4,  1'b1, 32'h0E006F4A},
        {25'd0,           4'd4,  1'b0, 32'h0},
        {25'h1FFFFFF,     4'd4,  1'b0, 32'h0},
        {25'd29357490,    4'd10, 1'b1, 32'hF29A73A4},
        {25'd0,           4'd10, 1'b0, 32'h0},
        {25'h1FFFFFF,     4'd10, 1'b0, 32'h0},
        {25'd0,           4'd12, 1'b0, 32'h0},
        {25'd3749850,     4'd1,  1'b1, 32'hEC0189AD},
        {25'd7150000,     4'd2,  1'b0, 32'h0},
        {25'd10125000,    4'd3,  1'b0, 32'h0},
        {25'd18117721,    4'd5,  1'b1, 32'hB66E36BC},
        {25'd21225000,    4'd6,  1'b0, 32'h0},
        {25'd28250000,    4'd8,  1'b0, 32'h0},
        {25'd28757490,    4'd9,  1'b1, 32'hEE11348D}
    };

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    vrts_req_if req();
    vrts_cmd_if cmd();

    vfo_rfreq_tuning_sequencer #(.NUM_BANDS(NUM_BANDS)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_cmd   (cmd)
    );

    t_cmd       cmds_due[$];
    logic [3:0] loaded_band = NO_BAND;
    int         n_fail = 0;
    int         src_idle_pct = 0;
    int         snk_stall_pct = 0;

    always #4 i_clk = ~i_clk;

    function automatic logic [31:0] tuned_rfreq(input logic [24:0] f, input logic [3:0] b);
        logic [31:0] sum;
        logic [31:0] span;
        logic [31:0] delta;
        logic        below;
        sum   = 32'(f) + CAL_HZ[b];
        below = sum < CTR_HZ[b];
        span  = below ? CTR_HZ[b] - sum : sum - CTR_HZ[b];
        delta = STEP_1K[b] * (span / 1000) + STEP_100[b] * ((span % 1000) / 100)
              + STEP_10[b] * ((span % 100) / 10);
        return below ? CTR_RFREQ[b] - delta : CTR_RFREQ[b] + delta;
    endfunction

    function automatic void add_cmd(input t_op op, input logic [7:0] a,
                                    input logic [7:0] d, input logic fin);
        t_cmd c;
        c.op   = op;
        c.addr = a;
        c.data = d;
        c.last = fin;
        cmds_due.push_back(c);
    endfunction

    function automatic void add_rfreq(input logic [31:0] rf);
        add_cmd(OP_WRITE, ADDR_RF_B3, rf[31:24], 1'b0);
        add_cmd(OP_WRITE, ADDR_RF_B2, rf[23:16], 1'b0);
        add_cmd(OP_WRITE, ADDR_RF_B1, rf[15:8], 1'b0);
        add_cmd(OP_WRITE, ADDR_RF_B0, rf[7:0], 1'b0);
    endfunction

    function automatic void predict_commands(input logic [24:0] f, input logic [3:0] b,
                                             input logic pinned, input logic [31:0] rf_pin);
        if (b >= NUM_BANDS || b >= TABLE_BANDS) return;
        if (b != loaded_band) begin
            loaded_band = b;
            add_cmd(OP_SET, ADDR_FREEZE, FREEZE_DCO, 1'b0);
            add_cmd(OP_WRITE, ADDR_HS_N1, HS_BYTE[b], 1'b0);
            add_cmd(OP_WRITE, ADDR_N1_RF, N1_BYTE[b], 1'b0);
            add_rfreq(CTR_RFREQ[b]);
            add_cmd(OP_CLR, ADDR_FREEZE, FREEZE_DCO, 1'b0);
            add_cmd(OP_WRITE, ADDR_FREQ_CTRL, CTRL_NEWFREQ, 1'b0);
        end
        add_cmd(OP_WRITE, ADDR_FREQ_CTRL, CTRL_FREEZE_M, 1'b0);
        add_rfreq(pinned ? rf_pin : tuned_rfreq(f, b));
        add_cmd(OP_WRITE, ADDR_FREQ_CTRL, CTRL_NONE, 1'b1);
    endfunction

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic send_request(input logic [24:0] f, input logic [3:0] b,
                                input logic pinned, input logic [31:0] rf_pin);
        while ($urandom_range(99) < src_idle_pct) begin
            req.valid <= 1'b0;
            @(negedge i_clk);
        end
        req.valid   <= 1'b1;
        req.freq_hz <= f;
        req.band    <= b;
        @(posedge i_clk);
        while (!req.ready) @(posedge i_clk);
        predict_commands(f, b, pinned, rf_pin);
        @(negedge i_clk);
    endtask

    always @(negedge i_clk) cmd.ready <= ($urandom_range(99) >= snk_stall_pct);

    always @(posedge i_clk) begin : check_cmds
        t_cmd want;
        if (i_rst_n && cmd.valid && cmd.ready) begin
            if (cmds_due.size() == 0) begin
                $error("unexpected command: op %0d addr %0d data 0x%02h last %0b",
                       cmd.op, cmd.reg_addr, cmd.reg_data, cmd.last);
                n_fail++;
            end else begin
                want = cmds_due.pop_front();
                if (cmd.op !== want.op) begin
                    $error("op: expected %0d, got %0d", want.op, cmd.op);
                    n_fail++;
                end
                if (cmd.reg_addr !== want.addr) begin
                    $error("reg_addr: expected %0d, got %0d", want.addr, cmd.reg_addr);
                    n_fail++;
                end
                if (cmd.reg_data !== want.data) begin
                    $error("reg_data: expected 0x%02h, got 0x%02h", want.data, cmd.reg_data);
                    n_fail++;
                end
                if (cmd.last !== want.last) begin
                    $error("last: expected %0b, got %0b", want.last, cmd.last);
                    n_fail++;
                end
            end
        end
    end

    initial begin
        #5000000;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin : stimulus
        int          i;
        int          n_tuned;
        int          roll;
        int          spread;
        logic [24:0] f;
        logic [3:0]  b;
        logic [3:0]  prev_band;
        req.valid   = 1'b0;
        req.freq_hz = '0;
        req.band    = '0;
        cmd.ready   = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (i = 0; i < $size(DIRECTED); i++) begin
            send_request(DIRECTED[i].freq, DIRECTED[i].band, DIRECTED[i].pinned,
                         DIRECTED[i].rf);
        end

        n_tuned   = 0;
        prev_band = 4'd0;
        while (n_tuned < N_RANDOM) begin
            src_idle_pct  = SRC_IDLE[n_tuned * 4 / N_RANDOM];
            snk_stall_pct = SNK_STALL[n_tuned * 4 / N_RANDOM];
            if ($urandom_range(99) < 8) begin
                b = 4'($urandom_range(15, 11));
                f = 25'($urandom);
            end else begin
                b = ($urandom_range(99) < 60) ? prev_band : 4'($urandom_range(10));
                prev_band = b;
                n_tuned++;
                roll = $urandom_range(99);
                if (roll < 70) begin
                    spread = int'($urandom_range(400000)) - 200000;
                end else begin
                    spread = int'($urandom_range(4000)) - 2000;
                end
                f = 25'(int'(CTR_HZ[b] - CAL_HZ[b]) + spread);
                if (roll >= 85) f = 25'($urandom);
            end
            send_request(f, b, 1'b0, 32'h0);
        end
        req.valid <= 1'b0;

        while (cmds_due.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (n_fail == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
